@@ rtl/core/aec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aec_pkg
// shared types and constants for the alarm escalation controller
// ----------------------------------------------------------------------------
package aec_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int FREQ_WIDTH  = 10;
    localparam int CFG_WIDTH   = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_CHIMES  = 5;
    localparam int CHIME_CNT_W = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;

    localparam logic [FREQ_WIDTH-1:0] FREQ_MIN = 10'd200;
    localparam logic [FREQ_WIDTH-1:0] FREQ_MAX = 10'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_TO_SPEAK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEAK_TO_ALARM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TO_FULL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_BLINK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_BLINK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_CHIME     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SIREN_TOGGLE   = 3'd7;

    typedef enum logic [2:0] {
        LVL_OFF   = 3'd0,
        LVL_FULL  = 3'd1,
        LVL_SIREN = 3'd2,
        LVL_TONE  = 3'd3,
        LVL_WARN  = 3'd4,
        LVL_GUARD = 3'd5
    } level_t;

    typedef enum logic [2:0] {
        CH_NONE   = 3'd0,
        CH_SINGLE = 3'd1,
        CH_DOUBLE = 3'd2,
        CH_LONG   = 3'd3,
        CH_LONGER = 3'd4
    } chime_t;

    // configuration write bundle
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_WIDTH-1:0] data;
    } cfg_wr_t;

    // one tick worth of results, as it travels through the queue
    typedef struct packed {
        logic [2:0]                     level;
        logic                           led;
        logic                           buzzer;
        logic                           spk_on;
        logic [FREQ_WIDTH-1:0]          freq;
        logic                           siren;
        chime_t [MAX_CHIMES-1:0]        kinds;
        logic [CHIME_CNT_W-1:0]         count;
    } tick_rec_t;

endpackage : aec_pkg
`default_nettype wire

@@ rtl/core/alarm_escalation_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_escalation_controller
// alarm level controller: one tick in, one to five chime results out
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: a tick transfers on a clock edge with push high
//   and full low. the tick engine runs the whole level step in that cycle and
//   writes one record into a four-entry record queue, so full only rises
//   when four ticks wait with results undelivered.
//   result side is a queue too: while empty is low the oldest result is on
//   the result ports, and it transfers on an edge with pop high. a tick
//   gives one result per chime (one result with chime_kind none when quiet),
//   last_result marks its final one.
//   the first result of a tick shows once its record is at the head of the
//   record queue. ticks go into the queue at one per cycle while full is low;
//   results leave at one per cycle while pop is high, 1..5 results per tick.
//   a stalled receiver only fills the record queue; the tick engine keeps
//   taking ticks until full.
//   reset (rst_n low, async) returns to the disarmed level, clears counters
//   and the queue, and loads the default timing registers.
//   configuration writes (cfg_we, cfg_index, cfg_data) apply to later ticks.
// ----------------------------------------------------------------------------
module alarm_escalation_controller
    import aec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_WIDTH-1:0]  cfg_data,
    // tick input
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [TIME_WIDTH-1:0] now_ms,
    input  wire logic                  armed,
    input  wire logic                  gate_open,
    input  wire logic                  panic,
    input  wire logic                  reset_button,
    input  wire logic                  lockdown,
    // results
    output logic                       empty,
    input  wire logic                  pop,
    output logic [2:0]                 alarm_level,
    output logic                       led_on,
    output logic                       buzzer_steady,
    output logic                       speaker_on,
    output logic [FREQ_WIDTH-1:0]      speaker_freq,
    output logic                       siren_on,
    output logic [2:0]                 chime_kind,
    output logic                       last_result
);

    cfg_wr_t   cfg;
    tick_rec_t new_rec;
    tick_rec_t head_rec;
    logic      step_en;
    logic      q_valid;
    logic      q_deq;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // a tick transfers whenever push is high and the record queue has room
    assign step_en = push && !full;

    aec_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step_en      (step_en),
        .now_ms       (now_ms),
        .armed        (armed),
        .gate_open    (gate_open),
        .panic        (panic),
        .reset_button (reset_button),
        .lockdown     (lockdown),
        .rec          (new_rec)
    );

    aec_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (step_en),
        .enq_rec (new_rec),
        .full    (full),
        .deq     (q_deq),
        .valid   (q_valid),
        .head    (head_rec)
    );

    aec_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (q_valid),
        .rec           (head_rec),
        .rec_done      (q_deq),
        .pop           (pop),
        .empty         (empty),
        .alarm_level   (alarm_level),
        .led_on        (led_on),
        .buzzer_steady (buzzer_steady),
        .speaker_on    (speaker_on),
        .speaker_freq  (speaker_freq),
        .siren_on      (siren_on),
        .chime_kind    (chime_kind),
        .last_result   (last_result)
    );

    // after a non-final result the rest of the same tick is still waiting
    a_tick_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_result) |=>
            (!empty && alarm_level == $past(alarm_level)
             && speaker_freq == $past(speaker_freq)))
        else $error("tick results split or changed mid-tick");

    // only a tick's final result may carry no chime
    a_quiet_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && chime_kind == CH_NONE) |-> last_result)
        else $error("empty chime before end of tick");

    // a tick whose results are pending keeps the queue from reporting empty
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !empty)
        else $error("accepted tick left no result");

endmodule : alarm_escalation_controller
`default_nettype wire

@@ rtl/core/aec_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aec_front
// level state machine: runs one tick per transfer and builds its record
// ----------------------------------------------------------------------------
module aec_front
    import aec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_wr_t               cfg,
    input  wire logic                  step_en,
    input  wire logic [TIME_WIDTH-1:0] now_ms,
    input  wire logic                  armed,
    input  wire logic                  gate_open,
    input  wire logic                  panic,
    input  wire logic                  reset_button,
    input  wire logic                  lockdown,
    output tick_rec_t                  rec
);

    typedef struct packed {
        chime_t [MAX_CHIMES-1:0] kinds;
        logic [CHIME_CNT_W-1:0]  count;
    } chime_list_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   fire;
    } cnt_step_t;

    function automatic chime_list_t add_chime(chime_list_t l, chime_t k);
        chime_list_t r;
        r = l;
        if (l.count < CHIME_CNT_W'(MAX_CHIMES))
        begin
            r.kinds[l.count] = k;
            r.count = l.count + 1'b1;
        end
        return r;
    endfunction

    function automatic cnt_step_t count_step(logic [COUNT_WIDTH-1:0] c,
                                             logic [COUNT_WIDTH-1:0] limit);
        cnt_step_t r;
        if (c >= limit)
        begin
            r.cnt  = '0;
            r.fire = 1'b1;
        end
        else
        begin
            r.cnt  = c + 1'b1;
            r.fire = 1'b0;
        end
        return r;
    endfunction

    // configuration
    logic [TIME_WIDTH-1:0]  warn_to_speak_reg, speak_to_alarm_reg, alarm_to_full_reg;
    logic [COUNT_WIDTH-1:0] guard_blink_reg, warn_blink_reg, warn_chime_reg;
    logic [COUNT_WIDTH-1:0] sweep_step_reg, siren_toggle_reg;

    // tick state
    level_t                 level_reg, level_next;
    logic [TIME_WIDTH-1:0]  entry_reg, entry_next;
    logic                   latch_reg, latch_next;
    logic [COUNT_WIDTH-1:0] blink_reg, blink_next;
    logic                   led_reg, led_next;
    logic [COUNT_WIDTH-1:0] chime_cnt_reg, chime_cnt_next;
    logic [COUNT_WIDTH-1:0] sweep_reg, sweep_next;
    logic [FREQ_WIDTH-1:0]  freq_reg, freq_next;
    logic                   tone_reg, tone_next;
    logic [COUNT_WIDTH-1:0] siren_cnt_reg, siren_cnt_next;
    logic                   siren_reg, siren_next;
    logic                   buzz_reg, buzz_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_to_speak_reg  <= TIME_WIDTH'(8000);
            speak_to_alarm_reg <= TIME_WIDTH'(8000);
            alarm_to_full_reg  <= TIME_WIDTH'(10000);
            guard_blink_reg    <= COUNT_WIDTH'(50000);
            warn_blink_reg     <= COUNT_WIDTH'(10000);
            warn_chime_reg     <= COUNT_WIDTH'(20000);
            sweep_step_reg     <= COUNT_WIDTH'(10);
            siren_toggle_reg   <= COUNT_WIDTH'(50000);
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_WARN_TO_SPEAK:  warn_to_speak_reg  <= cfg.data[TIME_WIDTH-1:0];
                CFG_SPEAK_TO_ALARM: speak_to_alarm_reg <= cfg.data[TIME_WIDTH-1:0];
                CFG_ALARM_TO_FULL:  alarm_to_full_reg  <= cfg.data[TIME_WIDTH-1:0];
                CFG_GUARD_BLINK:    guard_blink_reg    <= cfg.data[COUNT_WIDTH-1:0];
                CFG_WARN_BLINK:     warn_blink_reg     <= cfg.data[COUNT_WIDTH-1:0];
                CFG_WARN_CHIME:     warn_chime_reg     <= cfg.data[COUNT_WIDTH-1:0];
                CFG_SWEEP_STEP:     sweep_step_reg     <= cfg.data[COUNT_WIDTH-1:0];
                CFG_SIREN_TOGGLE:   siren_toggle_reg   <= cfg.data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [TIME_WIDTH-1:0] elapsed;
        chime_list_t           cl;
        cnt_step_t             cs;

        elapsed        = now_ms - entry_reg;
        cl             = '0;
        cs             = '0;
        level_next     = level_reg;
        entry_next     = entry_reg;
        latch_next     = latch_reg;
        blink_next     = blink_reg;
        led_next       = led_reg;
        chime_cnt_next = chime_cnt_reg;
        sweep_next     = sweep_reg;
        freq_next      = freq_reg;
        tone_next      = tone_reg;
        siren_cnt_next = siren_cnt_reg;
        siren_next     = siren_reg;
        buzz_next      = buzz_reg;

        // tone sweep runs in tone, siren and full levels
        if (level_reg == LVL_TONE || level_reg == LVL_SIREN || level_reg == LVL_FULL)
        begin
            cs = count_step(sweep_reg, sweep_step_reg);
            sweep_next = cs.cnt;
            if (cs.fire)
            begin
                freq_next = (freq_reg >= FREQ_MAX) ? FREQ_MIN : freq_reg + 1'b1;
                tone_next = 1'b1;
            end
        end

        case (level_reg)
            LVL_OFF:
            begin
                if (armed)
                begin
                    level_next = LVL_GUARD;
                    cl = add_chime(cl, CH_DOUBLE);
                end
            end
            LVL_GUARD:
            begin
                cs = count_step(blink_reg, guard_blink_reg);
                blink_next = cs.cnt;
                if (cs.fire)
                    led_next = !led_reg;
                if (armed)
                begin
                    if (gate_open)
                    begin
                        if (!latch_reg)
                        begin
                            if (lockdown)
                            begin
                                level_next = LVL_SIREN;
                                cl = add_chime(cl, CH_DOUBLE);
                                cl = add_chime(cl, CH_LONG);
                            end
                            else
                                level_next = LVL_WARN;
                            cl = add_chime(cl, CH_DOUBLE);
                        end
                    end
                    else
                        latch_next = 1'b0;
                end
                else
                begin
                    level_next = LVL_OFF;
                    cl = add_chime(cl, CH_SINGLE);
                end
                if (panic)
                begin
                    level_next = LVL_SIREN;
                    cl = add_chime(cl, CH_DOUBLE);
                    cl = add_chime(cl, CH_LONG);
                end
            end
            LVL_WARN, LVL_TONE:
            begin
                if (level_reg == LVL_WARN)
                begin
                    cs = count_step(blink_reg, warn_blink_reg);
                    blink_next = cs.cnt;
                    if (cs.fire)
                        led_next = !led_reg;
                    cs = count_step(chime_cnt_reg, warn_chime_reg);
                    chime_cnt_next = cs.cnt;
                    if (cs.fire)
                        cl = add_chime(cl, CH_SINGLE);
                end
                if (armed)
                begin
                    if (gate_open)
                    begin
                        if (level_reg == LVL_WARN && elapsed >= warn_to_speak_reg)
                        begin
                            level_next = LVL_TONE;
                            cl = add_chime(cl, CH_DOUBLE);
                        end
                        else if (level_reg == LVL_TONE && elapsed >= speak_to_alarm_reg)
                        begin
                            level_next = LVL_SIREN;
                            cl = add_chime(cl, CH_DOUBLE);
                            cl = add_chime(cl, CH_LONG);
                        end
                    end
                    else
                    begin
                        level_next = LVL_GUARD;
                        cl = add_chime(cl, CH_SINGLE);
                    end
                end
                else
                begin
                    level_next = LVL_OFF;
                    cl = add_chime(cl, CH_SINGLE);
                end
                if (panic)
                begin
                    level_next = LVL_SIREN;
                    cl = add_chime(cl, CH_DOUBLE);
                    cl = add_chime(cl, CH_LONG);
                end
                if (reset_button)
                begin
                    latch_next = 1'b1;
                    level_next = LVL_GUARD;
                    cl = add_chime(cl, CH_SINGLE);
                end
            end
            LVL_SIREN, LVL_FULL:
            begin
                buzz_next = 1'b1;
                cs = count_step(siren_cnt_reg, siren_toggle_reg);
                siren_cnt_next = cs.cnt;
                if (cs.fire)
                    siren_next = !siren_reg;
                if (armed)
                begin
                    if (level_reg == LVL_SIREN && elapsed >= alarm_to_full_reg)
                    begin
                        level_next = LVL_FULL;
                        cl = add_chime(cl, CH_DOUBLE);
                        cl = add_chime(cl, CH_LONGER);
                    end
                end
                else
                begin
                    level_next = LVL_OFF;
                    cl = add_chime(cl, CH_SINGLE);
                end
                if (reset_button)
                begin
                    latch_next = 1'b1;
                    level_next = LVL_GUARD;
                    cl = add_chime(cl, CH_SINGLE);
                end
            end
            default: ;
        endcase

        // any chime silences the buzzer
        if (cl.count != '0)
            buzz_next = 1'b0;

        if (level_next != level_reg)
        begin
            entry_next = now_ms;
            led_next   = 1'b0;
            buzz_next  = 1'b0;
            tone_next  = 1'b0;
            freq_next  = FREQ_MIN;
        end

        rec.level  = level_next;
        rec.led    = led_next;
        rec.buzzer = buzz_next;
        rec.spk_on = tone_next;
        rec.freq   = freq_next;
        rec.siren  = siren_next;
        rec.kinds  = cl.kinds;
        // a quiet tick still yields one result with no chime
        rec.count  = (cl.count == '0) ? CHIME_CNT_W'(1) : cl.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LVL_OFF;
            entry_reg     <= '0;
            latch_reg     <= 1'b0;
            blink_reg     <= '0;
            led_reg       <= 1'b0;
            chime_cnt_reg <= '0;
            sweep_reg     <= '0;
            freq_reg      <= FREQ_MIN;
            tone_reg      <= 1'b0;
            siren_cnt_reg <= '0;
            siren_reg     <= 1'b0;
            buzz_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            level_reg     <= level_next;
            entry_reg     <= entry_next;
            latch_reg     <= latch_next;
            blink_reg     <= blink_next;
            led_reg       <= led_next;
            chime_cnt_reg <= chime_cnt_next;
            sweep_reg     <= sweep_next;
            freq_reg      <= freq_next;
            tone_reg      <= tone_next;
            siren_cnt_reg <= siren_cnt_next;
            siren_reg     <= siren_next;
            buzz_reg      <= buzz_next;
        end
    end

endmodule : aec_front
`default_nettype wire

@@ rtl/core/aec_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aec_queue
// short record queue between the tick engine and the result sequencer
// ----------------------------------------------------------------------------
module aec_queue
    import aec_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      enq,
    input  wire tick_rec_t enq_rec,
    output logic           full,
    input  wire logic      deq,
    output logic           valid,
    output tick_rec_t      head
);

    tick_rec_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     fill_reg, fill_next;

    always_ff @(posedge clk)
    begin
        if (enq)
            mem[wr_ptr_reg] <= enq_rec;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (enq && !deq)
            fill_next = fill_reg + 1'b1;
        else if (!enq && deq)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    assign full  = (fill_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign valid = (fill_reg != '0);
    assign head  = mem[rd_ptr_reg];

endmodule : aec_queue
`default_nettype wire

@@ rtl/core/aec_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aec_back
// result sequencer: walks the chimes of the head record, one per transfer
// ----------------------------------------------------------------------------
module aec_back
    import aec_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rec_valid,
    input  wire tick_rec_t rec,
    output logic           rec_done,
    input  wire logic      pop,
    output logic           empty,
    output logic [2:0]     alarm_level,
    output logic           led_on,
    output logic           buzzer_steady,
    output logic           speaker_on,
    output logic [FREQ_WIDTH-1:0] speaker_freq,
    output logic           siren_on,
    output logic [2:0]     chime_kind,
    output logic           last_result
);

    logic [CHIME_CNT_W-1:0] idx_reg;
    logic                   xfer;

    assign empty         = !rec_valid;
    assign xfer          = pop && rec_valid;
    assign last_result   = (idx_reg == rec.count - 1'b1);
    assign rec_done      = xfer && last_result;

    assign alarm_level   = rec.level;
    assign led_on        = rec.led;
    assign buzzer_steady = rec.buzzer;
    assign speaker_on    = rec.spk_on;
    assign speaker_freq  = rec.freq;
    assign siren_on      = rec.siren;
    assign chime_kind    = (idx_reg < CHIME_CNT_W'(MAX_CHIMES)) ? rec.kinds[idx_reg] : CH_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (xfer)
            idx_reg <= last_result ? '0 : idx_reg + 1'b1;
    end

    // index stays inside the head record
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> idx_reg < rec.count)
        else $error("result index past record end");

    // index is back at zero whenever no record waits
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !rec_valid |-> idx_reg == '0)
        else $error("result index not cleared while empty");

    // a record always holds at least one result
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> (rec.count != '0 && rec.count <= CHIME_CNT_W'(MAX_CHIMES)))
        else $error("bad result count in record");

endmodule : aec_back
`default_nettype wire

@@ test/alarm_escalation_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_escalation_controller_tb
// self-checking bench for the alarm level controller
//
// ticks go in through the push/full queue port, results come out through the
// empty/pop port. a behavioral copy of the level logic runs beside the block:
// every accepted tick is stepped through it and the results it should give
// are queued, then each result that transfers out is compared field by field
// against the oldest queued one. directed sequences walk the levels, the
// reset latch, lockdown, time wrap and the timing register extremes; random
// traffic with random timing settings follows, plus a long receiver hold-off
// and a run in the full alarm level that steps the tone sweep every tick.
// ----------------------------------------------------------------------------
module alarm_escalation_controller_tb;

    import aec_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles without any transfer or register write
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off

    // one tick as it is offered to the block
    typedef struct packed {
        logic [TIME_WIDTH-1:0] now;
        logic                  armed;
        logic                  gate;
        logic                  panic;
        logic                  rbtn;
        logic                  lock;
    } tick_t;

    // one result as it should appear on the output ports
    typedef struct packed {
        logic [2:0]            level;
        logic                  led;
        logic                  buzz;
        logic                  spk;
        logic [FREQ_WIDTH-1:0] freq;
        logic                  siren;
        logic [2:0]            kind;
        logic                  last;
    } alarm_result_t;

    // behavioral copy of the controller state
    typedef struct {
        level_t                 level;
        logic [TIME_WIDTH-1:0]  entry;
        bit                     latch;
        bit                     led;
        bit                     buzz;
        bit                     tone_on;
        logic [FREQ_WIDTH-1:0]  freq;
        bit                     siren;
        logic [COUNT_WIDTH-1:0] blink_cnt;
        logic [COUNT_WIDTH-1:0] chime_cnt;
        logic [COUNT_WIDTH-1:0] sweep_cnt;
        logic [COUNT_WIDTH-1:0] siren_cnt;
    } ctl_state_t;

    // ------------------------------------------------------------------
    // block ports, all known from time zero
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_WIDTH-1:0]  cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [TIME_WIDTH-1:0] now_ms = '0;
    logic                  armed = 1'b0;
    logic                  gate_open = 1'b0;
    logic                  panic = 1'b0;
    logic                  reset_button = 1'b0;
    logic                  lockdown = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [2:0]            alarm_level;
    logic                  led_on;
    logic                  buzzer_steady;
    logic                  speaker_on;
    logic [FREQ_WIDTH-1:0] speaker_freq;
    logic                  siren_on;
    logic [2:0]            chime_kind;
    logic                  last_result;

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    ctl_state_t    ctl;
    chime_t        tick_chimes[$];     // chimes rung by the tick in progress
    alarm_result_t due_results[$];     // results still owed by the block
    alarm_result_t want;
    alarm_result_t got;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    int            send_gap_pct = 0;
    int            take_gap_pct = 0;
    int            hold_left = 0;
    logic [TIME_WIDTH-1:0] clock_ms = '0;
    bit            sw_armed = 1'b1;
    bit            sw_gate = 1'b0;

    // timing registers as the block should hold them, reset values first
    logic [TIME_WIDTH-1:0]  warn_to_speak  = 32'd8000;
    logic [TIME_WIDTH-1:0]  speak_to_alarm = 32'd8000;
    logic [TIME_WIDTH-1:0]  alarm_to_full  = 32'd10000;
    logic [COUNT_WIDTH-1:0] guard_blink    = 16'd50000;
    logic [COUNT_WIDTH-1:0] warn_blink     = 16'd10000;
    logic [COUNT_WIDTH-1:0] warn_chime     = 16'd20000;
    logic [COUNT_WIDTH-1:0] sweep_step     = 16'd10;
    logic [COUNT_WIDTH-1:0] siren_toggle   = 16'd50000;

    // values to load at the next configuration pass, by register index
    logic [CFG_WIDTH-1:0]   timing_plan [8];

    alarm_escalation_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .now_ms        (now_ms),
        .armed         (armed),
        .gate_open     (gate_open),
        .panic         (panic),
        .reset_button  (reset_button),
        .lockdown      (lockdown),
        .empty         (empty),
        .pop           (pop),
        .alarm_level   (alarm_level),
        .led_on        (led_on),
        .buzzer_steady (buzzer_steady),
        .speaker_on    (speaker_on),
        .speaker_freq  (speaker_freq),
        .siren_on      (siren_on),
        .chime_kind    (chime_kind),
        .last_result   (last_result)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // level logic predictor
    // ------------------------------------------------------------------

    // free-running event counter: fires and clears at or above its limit
    function automatic logic [COUNT_WIDTH-1:0] count_next(
        input logic [COUNT_WIDTH-1:0] cnt,
        input logic [COUNT_WIDTH-1:0] lim
    );
        return (cnt >= lim) ? '0 : cnt + 1'b1;
    endfunction

    // every chime silences the steady buzzer; at most five per tick
    function void ring(input chime_t k);
        if (tick_chimes.size() < MAX_CHIMES)
            tick_chimes.push_back(k);
        ctl.buzz = 1'b0;
    endfunction

    function void sweep_tone();
        if (ctl.sweep_cnt >= sweep_step)
        begin
            ctl.freq    = (ctl.freq >= FREQ_MAX) ? FREQ_MIN : ctl.freq + 1'b1;
            ctl.tone_on = 1'b1;
        end
        ctl.sweep_cnt = count_next(ctl.sweep_cnt, sweep_step);
    endfunction

    function void siren_hold();
        ctl.buzz = 1'b1;
        if (ctl.siren_cnt >= siren_toggle)
            ctl.siren = !ctl.siren;
        ctl.siren_cnt = count_next(ctl.siren_cnt, siren_toggle);
    endfunction

    // run one tick: level action, then transitions (later rules win),
    // then queue one result per chime, or a single quiet one
    task automatic escalate_tick(input tick_t tk);
        level_t                from_lvl;
        level_t                to_lvl;
        logic [TIME_WIDTH-1:0] elapsed;
        alarm_result_t         r;
        int                    n;
        int                    k;

        from_lvl = ctl.level;
        to_lvl   = from_lvl;
        elapsed  = tk.now - ctl.entry;     // wraps modulo 2^32 by width
        tick_chimes.delete();

        case (from_lvl)
            LVL_OFF:
            begin
                if (tk.armed)
                begin
                    to_lvl = LVL_GUARD;
                    ring(CH_DOUBLE);
                end
            end
            LVL_GUARD:
            begin
                if (ctl.blink_cnt >= guard_blink)
                    ctl.led = !ctl.led;
                ctl.blink_cnt = count_next(ctl.blink_cnt, guard_blink);
                if (tk.armed)
                begin
                    if (tk.gate)
                    begin
                        // a latched reset keeps an open gate from escalating
                        if (!ctl.latch)
                        begin
                            if (tk.lock)
                            begin
                                to_lvl = LVL_SIREN;
                                ring(CH_DOUBLE);
                                ring(CH_LONG);
                            end
                            else
                                to_lvl = LVL_WARN;
                            ring(CH_DOUBLE);
                        end
                    end
                    else
                        ctl.latch = 1'b0;
                end
                else
                begin
                    to_lvl = LVL_OFF;
                    ring(CH_SINGLE);
                end
                if (tk.panic)
                begin
                    to_lvl = LVL_SIREN;
                    ring(CH_DOUBLE);
                    ring(CH_LONG);
                end
            end
            LVL_WARN, LVL_TONE:
            begin
                if (from_lvl == LVL_WARN)
                begin
                    if (ctl.blink_cnt >= warn_blink)
                        ctl.led = !ctl.led;
                    ctl.blink_cnt = count_next(ctl.blink_cnt, warn_blink);
                    if (ctl.chime_cnt >= warn_chime)
                        ring(CH_SINGLE);
                    ctl.chime_cnt = count_next(ctl.chime_cnt, warn_chime);
                end
                else
                    sweep_tone();
                if (tk.armed)
                begin
                    if (tk.gate)
                    begin
                        if (from_lvl == LVL_WARN && elapsed >= warn_to_speak)
                        begin
                            to_lvl = LVL_TONE;
                            ring(CH_DOUBLE);
                        end
                        else if (from_lvl == LVL_TONE && elapsed >= speak_to_alarm)
                        begin
                            to_lvl = LVL_SIREN;
                            ring(CH_DOUBLE);
                            ring(CH_LONG);
                        end
                    end
                    else
                    begin
                        to_lvl = LVL_GUARD;
                        ring(CH_SINGLE);
                    end
                end
                else
                begin
                    to_lvl = LVL_OFF;
                    ring(CH_SINGLE);
                end
                if (tk.panic)
                begin
                    to_lvl = LVL_SIREN;
                    ring(CH_DOUBLE);
                    ring(CH_LONG);
                end
                if (tk.rbtn)
                begin
                    ctl.latch = 1'b1;
                    to_lvl    = LVL_GUARD;
                    ring(CH_SINGLE);
                end
            end
            LVL_SIREN, LVL_FULL:
            begin
                sweep_tone();
                siren_hold();
                if (tk.armed)
                begin
                    if (from_lvl == LVL_SIREN && elapsed >= alarm_to_full)
                    begin
                        to_lvl = LVL_FULL;
                        ring(CH_DOUBLE);
                        ring(CH_LONGER);
                    end
                end
                else
                begin
                    to_lvl = LVL_OFF;
                    ring(CH_SINGLE);
                end
                if (tk.rbtn)
                begin
                    ctl.latch = 1'b1;
                    to_lvl    = LVL_GUARD;
                    ring(CH_SINGLE);
                end
            end
            default:
            begin
            end
        endcase

        // a level change restarts the entry time and clears the outputs;
        // counters and the siren level carry over
        if (to_lvl != from_lvl)
        begin
            ctl.entry   = tk.now;
            ctl.led     = 1'b0;
            ctl.buzz    = 1'b0;
            ctl.tone_on = 1'b0;
            ctl.freq    = FREQ_MIN;
        end
        ctl.level = to_lvl;

        n = (tick_chimes.size() > 0) ? tick_chimes.size() : 1;
        for (k = 0; k < n; k++)
        begin
            r.level = ctl.level;
            r.led   = ctl.led;
            r.buzz  = ctl.buzz;
            r.spk   = ctl.tone_on;
            r.freq  = ctl.freq;
            r.siren = ctl.siren;
            r.kind  = (tick_chimes.size() > 0) ? tick_chimes[k] : CH_NONE;
            r.last  = (k == n - 1);
            due_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: pop pacing, long hold-off, and checking
    // ------------------------------------------------------------------

    // a hold-off request wins over the random pacing
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= take_gap_pct);
    end

    task note_field(input string name, input logic [31:0] w, input logic [31:0] g);
        if (w !== g)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, w, g);
            mismatches = mismatches + 1;
        end
    endtask

    // every result transfer is compared with the oldest result owed
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            got = '{alarm_level, led_on, buzzer_steady, speaker_on, speaker_freq,
                    siren_on, chime_kind, last_result};
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing owed, expected none, got level %0d chime %0d",
                         $time, got.level, got.kind);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = due_results.pop_front();
                note_field("alarm_level", 32'(want.level), 32'(got.level));
                note_field("led_on", 32'(want.led), 32'(got.led));
                note_field("buzzer_steady", 32'(want.buzz), 32'(got.buzz));
                note_field("speaker_on", 32'(want.spk), 32'(got.spk));
                note_field("speaker_freq", 32'(want.freq), 32'(got.freq));
                note_field("siren_on", 32'(want.siren), 32'(got.siren));
                note_field("chime_kind", 32'(want.kind), 32'(got.kind));
                note_field("last_result", 32'(want.last), 32'(got.last));
            end
        end
    end

    // hang detection: any transfer or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results owed",
                         $time, quiet_cycles, due_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tick side
    // ------------------------------------------------------------------

    // offer one tick, hold it until it transfers, then predict its results.
    // push stays high afterwards so back-to-back ticks need no extra edge
    task send_tick(input tick_t tk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        now_ms       <= tk.now;
        armed        <= tk.armed;
        gate_open    <= tk.gate;
        panic        <= tk.panic;
        reset_button <= tk.rbtn;
        lockdown     <= tk.lock;
        @(posedge clk);
        while (full)
            @(posedge clk);
        escalate_tick(tk);
    endtask

    task drive_tick(input logic [TIME_WIDTH-1:0] t, input bit a, input bit g,
                    input bit p, input bit r, input bit l);
        send_tick('{t, a, g, p, r, l});
    endtask

    // sticky switches and an advancing clock make escalation sequences;
    // now and then the time jumps anywhere
    task random_tick(input int max_gap_ms);
        tick_t tk;
        clock_ms = clock_ms + $urandom_range(max_gap_ms);
        if ($urandom_range(99) < 8)
            sw_armed = !sw_armed;
        if ($urandom_range(99) < 20)
            sw_gate = !sw_gate;
        tk.now   = ($urandom_range(99) < 4) ? $urandom : clock_ms;
        tk.armed = sw_armed;
        tk.gate  = sw_gate;
        tk.panic = ($urandom_range(99) < 6);
        tk.rbtn  = ($urandom_range(99) < 6);
        tk.lock  = ($urandom_range(99) < 25);
        send_tick(tk);
    endtask

    // stop offering ticks and wait until the block owes nothing
    task settle_block();
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task set_idling(input int send_pct, input int take_pct);
        send_gap_pct = send_pct;
        take_gap_pct = take_pct;
    endtask

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        // tick counts only keep their low half
        case (idx)
            CFG_WARN_TO_SPEAK:  warn_to_speak  = data;
            CFG_SPEAK_TO_ALARM: speak_to_alarm = data;
            CFG_ALARM_TO_FULL:  alarm_to_full  = data;
            CFG_GUARD_BLINK:    guard_blink    = data[COUNT_WIDTH-1:0];
            CFG_WARN_BLINK:     warn_blink     = data[COUNT_WIDTH-1:0];
            CFG_WARN_CHIME:     warn_chime     = data[COUNT_WIDTH-1:0];
            CFG_SWEEP_STEP:     sweep_step     = data[COUNT_WIDTH-1:0];
            CFG_SIREN_TOGGLE:   siren_toggle   = data[COUNT_WIDTH-1:0];
            default:
            begin
            end
        endcase
    endtask

    // only called with the block idle
    task write_timing_plan();
        int i;
        for (i = 0; i < 8; i++)
            cfg_write(CFG_IDX_W'(i), timing_plan[i]);
        cfg_we <= 1'b0;
    endtask

    task plan_all(input logic [CFG_WIDTH-1:0] v);
        int i;
        for (i = 0; i < 8; i++)
            timing_plan[i] = v;
    endtask

    function logic [CFG_WIDTH-1:0] pick_ms(input bit wide);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 12)
            return '1;
        if (wide && roll < 40)
            return $urandom;
        return $urandom_range(400);
    endfunction

    // tick counts: mostly short so the counters fire, junk in the upper half
    function logic [CFG_WIDTH-1:0] pick_ticks();
        int roll;
        logic [15:0] junk;
        roll = $urandom_range(99);
        junk = 16'($urandom_range(16'hFFFF));
        if (roll < 10)
            return {junk, 16'h0000};
        if (roll < 14)
            return {junk, 16'hFFFF};
        return {junk, 16'($urandom_range(6))};
    endfunction

    task plan_random_timing(input bit wide);
        timing_plan[CFG_WARN_TO_SPEAK]  = pick_ms(wide);
        timing_plan[CFG_SPEAK_TO_ALARM] = pick_ms(wide);
        timing_plan[CFG_ALARM_TO_FULL]  = pick_ms(wide);
        timing_plan[CFG_GUARD_BLINK]    = pick_ticks();
        timing_plan[CFG_WARN_BLINK]     = pick_ticks();
        timing_plan[CFG_WARN_CHIME]     = pick_ticks();
        timing_plan[CFG_SWEEP_STEP]     = pick_ticks();
        timing_plan[CFG_SIREN_TOGGLE]   = pick_ticks();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timing: arm/disarm, escalation exactly at each threshold,
    // entry time just below the wrap point, panic from the tone level
    task test_level_walk();
        drive_tick(32'd100,   0, 0, 0, 0, 0);   // stays disarmed, quiet
        drive_tick(32'd200,   1, 0, 0, 0, 0);   // guard
        drive_tick(32'd300,   0, 0, 0, 0, 0);   // back to disarmed
        drive_tick(32'd400,   1, 0, 0, 0, 0);
        drive_tick(32'd500,   1, 1, 0, 0, 0);   // gate opens: warn
        drive_tick(32'd8499,  1, 1, 0, 0, 0);   // one ms short
        drive_tick(32'd8500,  1, 1, 0, 0, 0);   // tone
        drive_tick(32'd16499, 1, 1, 0, 0, 0);
        drive_tick(32'd16500, 1, 1, 0, 0, 0);   // siren
        drive_tick(32'd26500, 1, 1, 0, 0, 0);   // full
        drive_tick(32'd26600, 0, 1, 0, 0, 0);   // disarmed
        drive_tick(32'hFFFF_FF00, 1, 0, 0, 0, 0);
        drive_tick(32'hFFFF_FF80, 1, 1, 0, 0, 0);  // warn near the wrap
        drive_tick(32'h0000_1EC0, 1, 1, 0, 0, 0);  // 8000 ms across the wrap
        drive_tick(32'h0000_1F00, 1, 1, 1, 0, 0);  // panic in tone
    endtask

    // reset latch, lockdown with panic (five chimes), reset button
    task test_latch_and_lockdown();
        drive_tick(32'h2000, 1, 1, 0, 1, 0);   // reset button in siren
        drive_tick(32'h2100, 1, 1, 0, 0, 1);   // latched: open gate ignored
        drive_tick(32'h2200, 1, 0, 0, 0, 0);   // closed gate clears the latch
        drive_tick(32'h2300, 1, 1, 1, 0, 1);   // lockdown plus panic
        drive_tick(32'h2400, 0, 1, 1, 1, 0);   // disarm and reset together
        drive_tick(32'h2500, 1, 1, 0, 0, 0);
        drive_tick(32'h2600, 1, 0, 0, 0, 1);
        drive_tick(32'h2700, 1, 1, 0, 0, 0);   // warn
        drive_tick(32'h2800, 1, 0, 0, 1, 0);   // gate closes and reset
    endtask

    // all timing registers at zero, then all at their maximum
    task test_timing_extremes();
        settle_block();
        plan_all('0);
        write_timing_plan();
        drive_tick(32'h3000, 1, 0, 0, 0, 0);
        drive_tick(32'h3100, 1, 1, 0, 0, 0);
        drive_tick(32'h3200, 1, 1, 1, 1, 0);   // every rule fires in warn
        settle_block();
        plan_all('1);
        write_timing_plan();
        drive_tick(32'd1, 1, 0, 0, 0, 0);
        drive_tick(32'd1, 1, 1, 0, 0, 0);      // warn entered at 1
        drive_tick(32'd0, 1, 1, 0, 0, 0);      // elapsed is all ones
        drive_tick(32'd5, 1, 1, 0, 0, 0);
    endtask

    task test_random_traffic(input int count, input bit wide);
        settle_block();
        plan_random_timing(wide);
        write_timing_plan();
        repeat (count)
            random_tick(120);
    endtask

    // receiver stops for a long stretch while ticks keep coming
    task test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (24)
            random_tick(120);
    endtask

    // full alarm with a step every tick: the sweep climbs on each tick
    task test_sweep_wrap();
        settle_block();
        plan_random_timing(1'b0);
        timing_plan[CFG_SWEEP_STEP]    = '0;
        timing_plan[CFG_ALARM_TO_FULL] = '0;
        write_timing_plan();
        drive_tick(clock_ms, 0, 0, 0, 0, 0);
        drive_tick(clock_ms, 1, 0, 0, 0, 0);
        drive_tick(clock_ms, 1, 0, 0, 0, 0);   // latch cleared
        drive_tick(clock_ms, 1, 1, 0, 0, 1);   // siren through lockdown
        drive_tick(clock_ms, 1, 0, 0, 0, 0);   // full at once
        repeat (60)
            drive_tick($urandom, 1, 1'($urandom_range(1)), 1'($urandom_range(1)), 0,
                       1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial
    begin
        ctl.level     = LVL_OFF;
        ctl.entry     = '0;
        ctl.latch     = 1'b0;
        ctl.led       = 1'b0;
        ctl.buzz      = 1'b0;
        ctl.tone_on   = 1'b0;
        ctl.freq      = FREQ_MIN;
        ctl.siren     = 1'b0;
        ctl.blink_cnt = '0;
        ctl.chime_cnt = '0;
        ctl.sweep_cnt = '0;
        ctl.siren_cnt = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow receiver, slow sender, then neither
        set_idling(14, 71);
        test_level_walk();
        test_latch_and_lockdown();
        test_timing_extremes();
        test_random_traffic(100, 1'b0);

        settle_block();
        set_idling(71, 14);
        test_random_traffic(90, 1'b0);
        test_backpressure();

        settle_block();
        set_idling(0, 0);
        test_sweep_wrap();
        test_random_traffic(70, 1'b1);

        // drain, then give a late extra result time to show up
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
